@@ src/qtg_pkg.sv @@
`default_nettype none
package qtg_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COEFF_COUNT = 6;
	localparam int COEF_FRAC   = 32;

	localparam logic CMD_PLAN = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SAT    = 2'd1;
	localparam logic [1:0] ST_NOPLAN = 2'd2;

	localparam logic [2:0] REG_DURATION  = 3'd0;
	localparam logic [2:0] REG_START_POS = 3'd1;
	localparam logic [2:0] REG_END_POS   = 3'd2;
	localparam logic [2:0] REG_START_VEL = 3'd3;
	localparam logic [2:0] REG_END_VEL   = 3'd4;
	localparam logic [2:0] REG_START_ACC = 3'd5;
	localparam logic [2:0] REG_END_ACC   = 3'd6;

	localparam logic [31:0] DURATION_RESET = 32'h0001_0000;

	typedef struct packed {
		logic        command;
		logic [31:0] time_offset;
	} req_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic [1:0]         status;
	} rsp_t;

endpackage
`default_nettype wire

@@ src/quintic_trajectory_generator_unit.sv @@
// Quintic trajectory generator. Registers hold the segment duration and the start and end
// position, velocity and acceleration (Q16.16 by default); a plan item solves and stores the
// six coefficients, an evaluate item returns the position at a time since segment start by
// Horner evaluation, saturated to 32 bits with a status flag. One item is in work at a time
// and req_ready is low meanwhile. Evaluate uses the limb-serial 33x33 multiplier, which
// steps through the 32-bit limbs of the accumulator. Plan uses it as well as the bit-serial
// divider, which steps through the dividend bits and divides by the duration three, four
// and five times. Configuration writes are taken every cycle and must only be made while
// no item is in work.
`default_nettype none
module quintic_trajectory_generator_unit #(
	parameter int FRAC_BITS = qtg_pkg::FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire qtg_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output qtg_pkg::rsp_t      rsp
);

	localparam int CF    = qtg_pkg::COEF_FRAC;
	localparam int NCOEF = qtg_pkg::COEFF_COUNT;
	localparam int LIMBS = (64 + 5 * (32 - FRAC_BITS) + 34 + 31) / 32;
	localparam int AW    = 32 * LIMBS;
	localparam int LB    = $clog2(LIMBS);
	localparam int NW    = 40;
	localparam int NB    = 101;
	localparam int DW    = NB + CF + 2 * FRAC_BITS;
	localparam int BW    = $clog2(DW);
	localparam logic [LB-1:0] LIMB_TOP = LB'(LIMBS - 1);
	localparam logic [BW-1:0] BIT_LAST = BW'(DW - 1);

	localparam logic [2:0] IDX_C3   = 3'd3;
	localparam logic [2:0] IDX_C4   = 3'd4;
	localparam logic [2:0] IDX_LAST = 3'(NCOEF - 1);
	localparam logic [2:0] IDX_EV   = 3'(NCOEF - 2);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_PL_BEGIN = 4'd1;
	localparam logic [3:0] S_PL_START = 4'd2;
	localparam logic [3:0] S_MUL      = 4'd3;
	localparam logic [3:0] S_PL_ADDV  = 4'd4;
	localparam logic [3:0] S_PL_ADDH  = 4'd5;
	localparam logic [3:0] S_PL_LOAD  = 4'd6;
	localparam logic [3:0] S_DIV      = 4'd7;
	localparam logic [3:0] S_PL_ROUND = 4'd8;
	localparam logic [3:0] S_EV_START = 4'd9;
	localparam logic [3:0] S_EV_SHIFT = 4'd10;
	localparam logic [3:0] S_EV_ADD   = 4'd11;
	localparam logic [3:0] S_EV_FIN   = 4'd12;
	localparam logic [3:0] S_OUT      = 4'd13;

	logic [31:0] dur_q, sp_q, ep_q, sv_q, ev_q, sa_q, ea_q;
	logic [63:0] coef_q [NCOEF];
	logic        plan_valid_q;

	logic [3:0]    state_q, ret_q;
	logic          pl_mode_q, neg_q, sat_q;
	logic [31:0]   t_q, rem_q;
	logic [2:0]    idx_q, pass_q;
	logic [LB-1:0] limb_q;
	logic [BW-1:0] bcnt_q;
	logic [AW-1:0] acc_q, src_q;
	logic [DW-1:0] dr_q;
	qtg_pkg::rsp_t res_q, rsp_q;
	logic          rsp_valid_q;

	function automatic logic [AW-1:0] rnd_shr(input logic [AW-1:0] v, input int unsigned sh);
		logic [AW-1:0] bias;
		logic [AW-1:0] s;
		bias = {{(AW-1){1'b0}}, 1'b1} << (sh - 1);
		if (v[AW-1]) begin
			bias = bias - {{(AW-1){1'b0}}, 1'b1};
		end
		s = v + bias;
		return $unsigned($signed(s) >>> sh);
	endfunction

	// numerator terms
	logic [NW-1:0] p0, p1, v0, v1, a0, a1, h, hc, vc, ac;
	always_comb begin
		p0 = {{(NW-32){sp_q[31]}}, sp_q};
		p1 = {{(NW-32){ep_q[31]}}, ep_q};
		v0 = {{(NW-32){sv_q[31]}}, sv_q};
		v1 = {{(NW-32){ev_q[31]}}, ev_q};
		a0 = {{(NW-32){sa_q[31]}}, sa_q};
		a1 = {{(NW-32){ea_q[31]}}, ea_q};
		h  = p1 - p0;
		unique case (idx_q)
			IDX_C3: begin
				hc = h * NW'(20);
				vc = NW'(0) - (v1 * NW'(8) + v0 * NW'(12));
				ac = a1 - a0 * NW'(3);
			end
			IDX_C4: begin
				hc = NW'(0) - h * NW'(30);
				vc = v1 * NW'(14) + v0 * NW'(16);
				ac = a0 * NW'(3) - a1 * NW'(2);
			end
			default: begin
				hc = h * NW'(12);
				vc = NW'(0) - (v0 + v1) * NW'(6);
				ac = a1 - a0;
			end
		endcase
	end

	// shared multiplier and wide adders
	logic [31:0]        limb, mul_m;
	logic signed [32:0] pa, pb;
	logic signed [65:0] prod;
	logic [AW-1:0]      mul_next, vc_sh, hc_sh, mag, ev_sum, fin;
	logic [AW-1:0]      ac_x, c5_x;
	logic [DW-1:0]      dr_load;
	logic [32:0]        cur, cur_sub;
	logic               ge;
	logic [DW:0]        qp;
	logic [DW-1:0]      rr;
	logic               csat, fit;
	logic [63:0]        cmag, cval;
	logic [31:0]        pos_sat;
	always_comb begin
		limb     = src_q[limb_q * 32 +: 32];
		mul_m    = pl_mode_q ? dur_q : t_q;
		pa       = (limb_q == LIMB_TOP) ? {limb[31], limb} : {1'b0, limb};
		pb       = {1'b0, mul_m};
		prod     = pa * pb;
		mul_next = {acc_q[AW-33:0], 32'b0} + {{(AW-66){prod[65]}}, prod};
		ac_x     = {{(AW-NW){ac[NW-1]}}, ac};
		c5_x     = {{(AW-64){coef_q[NCOEF-1][63]}}, coef_q[NCOEF-1]};
		vc_sh    = {{(AW-NW){vc[NW-1]}}, vc} << FRAC_BITS;
		hc_sh    = {{(AW-NW){hc[NW-1]}}, hc} << (2 * FRAC_BITS);
		mag      = acc_q[AW-1] ? (AW'(0) - acc_q) : acc_q;
		unique case (idx_q)
			IDX_C3:  dr_load = {{(DW-NB){1'b0}}, mag[NB-1:0]} << CF;
			IDX_C4:  dr_load = {{(DW-NB){1'b0}}, mag[NB-1:0]} << (CF + FRAC_BITS);
			default: dr_load = {{(DW-NB){1'b0}}, mag[NB-1:0]} << (CF + 2 * FRAC_BITS);
		endcase
		cur     = {rem_q, dr_q[DW-1]};
		cur_sub = cur - {1'b0, dur_q};
		ge      = cur >= {1'b0, dur_q};
		qp      = {1'b0, dr_q} + {{DW{1'b0}}, 1'b1};
		rr      = qp[DW:1];
		if (neg_q) begin
			csat = (|rr[DW-1:64]) || (rr[63] && (|rr[62:0]));
			cmag = csat ? 64'h8000_0000_0000_0000 : rr[63:0];
		end else begin
			csat = |rr[DW-1:63];
			cmag = csat ? 64'h7FFF_FFFF_FFFF_FFFF : rr[63:0];
		end
		cval    = neg_q ? (64'd0 - cmag) : cmag;
		ev_sum  = acc_q + {{(AW-64){coef_q[idx_q][63]}}, coef_q[idx_q]};
		fin     = rnd_shr(acc_q, CF - FRAC_BITS);
		fit     = (&fin[AW-1:31]) || !(|fin[AW-1:31]);
		pos_sat = fin[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	end

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q        <= qtg_pkg::DURATION_RESET;
			sp_q         <= '0;
			ep_q         <= '0;
			sv_q         <= '0;
			ev_q         <= '0;
			sa_q         <= '0;
			ea_q         <= '0;
			for (int i = 0; i < NCOEF; i++) begin
				coef_q[i] <= '0;
			end
			plan_valid_q <= 1'b0;
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			pl_mode_q    <= 1'b0;
			neg_q        <= 1'b0;
			sat_q        <= 1'b0;
			t_q          <= '0;
			rem_q        <= '0;
			idx_q        <= '0;
			pass_q       <= '0;
			limb_q       <= '0;
			bcnt_q       <= '0;
			acc_q        <= '0;
			src_q        <= '0;
			dr_q         <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					qtg_pkg::REG_DURATION:  dur_q <= cfg_data;
					qtg_pkg::REG_START_POS: sp_q  <= cfg_data;
					qtg_pkg::REG_END_POS:   ep_q  <= cfg_data;
					qtg_pkg::REG_START_VEL: sv_q  <= cfg_data;
					qtg_pkg::REG_END_VEL:   ev_q  <= cfg_data;
					qtg_pkg::REG_START_ACC: sa_q  <= cfg_data;
					qtg_pkg::REG_END_ACC:   ea_q  <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp_ready && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						t_q       <= req.time_offset;
						pl_mode_q <= (req.command == qtg_pkg::CMD_PLAN);
						state_q   <= (req.command == qtg_pkg::CMD_PLAN) ? S_PL_BEGIN
							: S_EV_START;
					end
				end
				S_PL_BEGIN: begin
					if (dur_q == 32'd0) begin
						plan_valid_q <= 1'b0;
						res_q        <= {sp_q, qtg_pkg::ST_NOPLAN};
						state_q      <= S_OUT;
					end else begin
						coef_q[0] <= {{32{sp_q[31]}}, sp_q} << (CF - FRAC_BITS);
						coef_q[1] <= {{32{sv_q[31]}}, sv_q} << (CF - FRAC_BITS);
						coef_q[2] <= {{32{sa_q[31]}}, sa_q} << (CF - FRAC_BITS - 1);
						sat_q     <= 1'b0;
						idx_q     <= IDX_C3;
						state_q   <= S_PL_START;
					end
				end
				S_PL_START: begin
					src_q   <= ac_x;
					acc_q   <= '0;
					limb_q  <= LIMB_TOP;
					ret_q   <= S_PL_ADDV;
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= mul_next;
					if (limb_q == '0) begin
						state_q <= ret_q;
					end else begin
						limb_q <= limb_q - 1'b1;
					end
				end
				S_PL_ADDV: begin
					src_q   <= acc_q + vc_sh;
					acc_q   <= '0;
					limb_q  <= LIMB_TOP;
					ret_q   <= S_PL_ADDH;
					state_q <= S_MUL;
				end
				S_PL_ADDH: begin
					acc_q   <= acc_q + hc_sh;
					state_q <= S_PL_LOAD;
				end
				S_PL_LOAD: begin
					neg_q   <= acc_q[AW-1];
					dr_q    <= dr_load;
					rem_q   <= '0;
					bcnt_q  <= '0;
					pass_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dr_q <= {dr_q[DW-2:0], ge};
					if (bcnt_q == BIT_LAST) begin
						bcnt_q <= '0;
						rem_q  <= '0;
						if (pass_q == idx_q - 3'd1) begin
							state_q <= S_PL_ROUND;
						end else begin
							pass_q <= pass_q + 3'd1;
						end
					end else begin
						rem_q  <= ge ? cur_sub[31:0] : cur[31:0];
						bcnt_q <= bcnt_q + 1'b1;
					end
				end
				S_PL_ROUND: begin
					coef_q[idx_q] <= cval;
					sat_q         <= sat_q | csat;
					if (idx_q == IDX_LAST) begin
						plan_valid_q <= 1'b1;
						res_q        <= {sp_q, (sat_q | csat) ? qtg_pkg::ST_SAT
							: qtg_pkg::ST_OK};
						state_q      <= S_OUT;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_PL_START;
					end
				end
				S_EV_START: begin
					if (!plan_valid_q) begin
						res_q   <= {32'd0, qtg_pkg::ST_NOPLAN};
						state_q <= S_OUT;
					end else begin
						src_q   <= c5_x;
						acc_q   <= '0;
						limb_q  <= LIMB_TOP;
						idx_q   <= IDX_EV;
						ret_q   <= S_EV_SHIFT;
						state_q <= S_MUL;
					end
				end
				S_EV_SHIFT: begin
					acc_q   <= rnd_shr(acc_q, FRAC_BITS);
					state_q <= S_EV_ADD;
				end
				S_EV_ADD: begin
					if (idx_q == '0) begin
						acc_q   <= ev_sum;
						state_q <= S_EV_FIN;
					end else begin
						src_q   <= ev_sum;
						acc_q   <= '0;
						limb_q  <= LIMB_TOP;
						idx_q   <= idx_q - 3'd1;
						ret_q   <= S_EV_SHIFT;
						state_q <= S_MUL;
					end
				end
				S_EV_FIN: begin
					res_q   <= fit ? {fin[31:0], qtg_pkg::ST_OK} : {pos_sat, qtg_pkg::ST_SAT};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
